@@ src/ttbu_pkg.sv @@
// Shared types and constants for the two-type bracket unranking block.
// Used by the path-count table, the completion counter and the top level.
package ttbu_pkg;

  localparam int MAX_PAIRS = 20;
  localparam int LEN_DIM   = 2 * MAX_PAIRS + 1;
  localparam int HT_DIM    = MAX_PAIRS + 1;

  localparam int PAIR_W  = 5;
  localparam int RANK_W  = 53;
  localparam int CNT_W   = 38;
  localparam int CMP_W   = CNT_W + MAX_PAIRS;
  localparam int SUM_W   = CMP_W + 2;
  localparam int POS_W   = 6;
  localparam int ROW_AW  = 6;
  localparam int DEPTH_W = 5;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef cnt_t [HT_DIM-1:0]  row_t;

  typedef enum logic [1:0] {
    SYM_ROUND_OPEN   = 2'd0,
    SYM_ROUND_CLOSE  = 2'd1,
    SYM_SQUARE_OPEN  = 2'd2,
    SYM_SQUARE_CLOSE = 2'd3
  } sym_e;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_TOT,
    S_OOR,
    S_CNT,
    S_SUM,
    S_DEC
  } state_e;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } tbl_rd_t;

endpackage

@@ src/ttbu_table.sv @@
// Path-count table: one row per path length, one 38-bit count per height.
// Filled by a sweep of one row a cycle; depends on ttbu_pkg.
module ttbu_table import ttbu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fill_start_i,
  input  logic [PAIR_W-1:0] n_i,
  input  tbl_rd_t           rd_i,
  output row_t              rd_row_o,
  output logic              busy_o
);

  row_t              tbl_mem_q [LEN_DIM];
  row_t              prev_q;
  row_t              rd_row_q;
  row_t              row_new;
  cnt_t              ext [HT_DIM+2];
  logic              busy_q;
  logic [ROW_AW-1:0] idx_q;

  // Pad the previous row so each height sees its lower and upper neighbour
  always_comb begin
    ext[0]        = '0;
    ext[HT_DIM+1] = '0;
    for (int k = 0; k < HT_DIM; k++) begin
      ext[k+1] = prev_q[k];
    end
  end

  // Build the next row from the previous one, bounded by the pair count
  always_comb begin
    for (int j = 0; j < HT_DIM; j++) begin
      row_new[j] = '0;
      if (idx_q == '0) begin
        if (j == 0) row_new[j] = CNT_W'(1);
      end else if (PAIR_W'(j) <= n_i) begin
        row_new[j] = ext[j];
        if (PAIR_W'(j + 1) <= n_i) row_new[j] = ext[j] + ext[j+2];
      end
    end
  end

  // Sweep control: restart on request, stop after the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fill_start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      if (idx_q == ROW_AW'(LEN_DIM - 1)) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + 1'b1;
    end
  end

  // Write one row per sweep cycle, hold it as the base of the next
  always_ff @(posedge clk_i) begin
    if (busy_q && !fill_start_i) begin
      tbl_mem_q[idx_q] <= row_new;
      prev_q           <= row_new;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_row_q <= tbl_mem_q[rd_i.addr];
    end
  end

  assign rd_row_o = rd_row_q;
  assign busy_o   = busy_q;

endmodule

@@ src/ttbu_count.sv @@
// Completion counter: picks one height from a table row and scales it by the
// number of kind choices left. Depends on ttbu_pkg.
module ttbu_count import ttbu_pkg::*; (
  input  row_t              row_i,
  input  logic [POS_W-1:0]  rest_i,
  input  logic [POS_W-1:0]  h_i,
  input  logic [PAIR_W-1:0] n_i,
  output logic [CMP_W-1:0]  c_o
);

  logic [POS_W-1:0]   diff;
  logic [DEPTH_W-1:0] sh;

  // Each remaining pair beyond the height may be round or square
  always_comb begin
    diff = rest_i - h_i;
    sh   = diff[POS_W-1:1];
    if ((h_i > {1'b0, n_i}) || (h_i > rest_i)) begin
      c_o = '0;
    end else begin
      c_o = CMP_W'(row_i[h_i[DEPTH_W-1:0]]) << sh;
    end
  end

endmodule

@@ src/two_type_bracket_unrank.sv @@
// Two-type bracket unranking, top level. After the rank transfer the total count
// is checked first; then each symbol is found in turn (read row, count, sum,
// decide); an out-of-range rank gives one flagged result.
// Throughput is set by the per-symbol count/sum/compare loop on the table row.
// After reset, and after each pair_count write, the table is refilled and input
// is stalled until the fill is done. Depends on ttbu_pkg, ttbu_table, ttbu_count.
module two_type_bracket_unrank import ttbu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAIR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [RANK_W-1:0] rank_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        symbol_o,
  output logic              out_of_range_o,
  output logic              last_o
);

  state_e             state_q, state_d;
  logic [PAIR_W-1:0]  pair_count_q;
  logic [PAIR_W-1:0]  n_eff;
  logic [POS_W-1:0]   two_n;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   rest;
  logic [DEPTH_W-1:0] depth_q;
  logic [DEPTH_W-1:0] dm1;
  logic [RANK_W-1:0]  rank_q;
  logic [CMP_W-1:0]   c1_q, c2_q;
  logic [SUM_W-1:0]   s_q, t_q;
  logic [MAX_PAIRS-1:0] stack_q;

  logic               out_valid_q;
  sym_e               out_sym_q;
  logic               out_oor_q, out_last_q;

  tbl_rd_t            rd_req;
  row_t               row;
  logic               tbl_busy;
  logic [POS_W-1:0]   rest_a, h_a, h_b;
  logic [CMP_W-1:0]   c_a, c_b;
  logic               close_ok;
  logic               tot_oor;
  logic               out_load;
  logic               accept;
  logic               emit;
  logic               dec_fire;

  logic [SUM_W-1:0]   rank_x;
  logic               lt1, lt2, lt3;
  sym_e               dec_sym;
  logic [RANK_W-1:0]  rank_new;
  logic               is_open;

  // Clamp the configured pair count
  always_comb begin
    if (pair_count_q == '0) begin
      n_eff = PAIR_W'(1);
    end else if (pair_count_q > PAIR_W'(MAX_PAIRS)) begin
      n_eff = PAIR_W'(MAX_PAIRS);
    end else begin
      n_eff = pair_count_q;
    end
  end

  assign two_n = {n_eff, 1'b0};
  assign rest  = pos_q - 1'b1;
  assign dm1   = (depth_q != '0) ? depth_q - 1'b1 : '0;

  ttbu_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fill_start_i (cfg_we_i),
    .n_i          (n_eff),
    .rd_i         (rd_req),
    .rd_row_o     (row),
    .busy_o       (tbl_busy)
  );

  // Opening choice (also the total at run start) and closing choice
  assign rest_a = (state_q == S_TOT) ? two_n : rest;
  assign h_a    = (state_q == S_TOT) ? '0 : POS_W'(depth_q) + 1'b1;
  assign h_b    = POS_W'(depth_q) - 1'b1;

  ttbu_count u_count_open (
    .row_i  (row),
    .rest_i (rest_a),
    .h_i    (h_a),
    .n_i    (n_eff),
    .c_o    (c_a)
  );

  ttbu_count u_count_close (
    .row_i  (row),
    .rest_i (rest),
    .h_i    (h_b),
    .n_i    (n_eff),
    .c_o    (c_b)
  );

  // A round close is only possible over a round open
  assign close_ok = (depth_q != '0) && (stack_q[dm1] == 1'b0);
  assign tot_oor  = SUM_W'(rank_q) >= SUM_W'(c_a);
  assign out_load = !out_valid_q || !out_stall_i;

  // Decide the symbol from the remaining rank and the choice counts
  always_comb begin
    rank_x = SUM_W'(rank_q);
    lt1    = rank_x < SUM_W'(c1_q);
    lt2    = rank_x < s_q;
    lt3    = rank_x < t_q;
    if (lt1) begin
      dec_sym  = SYM_ROUND_OPEN;
      rank_new = rank_q;
    end else if (lt2) begin
      dec_sym  = SYM_ROUND_CLOSE;
      rank_new = RANK_W'(rank_x - SUM_W'(c1_q));
    end else if (lt3) begin
      dec_sym  = SYM_SQUARE_OPEN;
      rank_new = RANK_W'(rank_x - s_q);
    end else begin
      dec_sym  = SYM_SQUARE_CLOSE;
      rank_new = RANK_W'(rank_x - t_q);
    end
    is_open = (dec_sym == SYM_ROUND_OPEN) || (dec_sym == SYM_SQUARE_OPEN);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_FILL: if (!tbl_busy) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_TOT;
      S_TOT:  state_d = tot_oor ? S_OOR : S_CNT;
      S_OOR:  if (out_load) state_d = S_IDLE;
      S_CNT:  state_d = S_SUM;
      S_SUM:  state_d = S_DEC;
      S_DEC: begin
        if (out_load) state_d = (rest == '0) ? S_IDLE : S_CNT;
      end
      default: state_d = S_FILL;
    endcase
    if (cfg_we_i) state_d = S_FILL;
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE) || cfg_we_i;
    accept     = in_valid_i && !in_stall_o;
    emit       = 1'b0;
    dec_fire   = 1'b0;
    rd_req     = '{en: 1'b0, addr: '0};
    case (state_q)
      S_IDLE: begin
        if (accept) rd_req = '{en: 1'b1, addr: ROW_AW'(two_n)};
      end
      S_TOT: begin
        if (!tot_oor) rd_req = '{en: 1'b1, addr: ROW_AW'(two_n - 1'b1)};
      end
      S_OOR: begin
        emit = out_load;
      end
      S_DEC: begin
        emit     = out_load;
        dec_fire = out_load;
        if (out_load && (rest != '0)) rd_req = '{en: 1'b1, addr: ROW_AW'(rest - 1'b1)};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state and run registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_FILL;
      pair_count_q <= PAIR_W'(1);
      pos_q        <= '0;
      depth_q      <= '0;
      rank_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pair_count_q <= cfg_wdata_i;
      if (accept) rank_q <= rank_i;
      if ((state_q == S_TOT) && !tot_oor) begin
        pos_q   <= two_n;
        depth_q <= '0;
      end
      if (dec_fire) begin
        rank_q <= rank_new;
        pos_q  <= rest;
        if (is_open) begin
          if (depth_q < DEPTH_W'(MAX_PAIRS)) depth_q <= depth_q + 1'b1;
        end else if (depth_q != '0) begin
          depth_q <= depth_q - 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: choice counts, sums, open-kind stack, result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_CNT) begin
      c1_q <= c_a;
      c2_q <= close_ok ? c_b : '0;
    end
    if (state_q == S_SUM) begin
      s_q <= SUM_W'(c1_q) + SUM_W'(c2_q);
      t_q <= (SUM_W'(c1_q) << 1) + SUM_W'(c2_q);
    end
    if (dec_fire && is_open && (depth_q < DEPTH_W'(MAX_PAIRS))) begin
      stack_q[depth_q] <= (dec_sym == SYM_SQUARE_OPEN);
    end
    if (emit) begin
      if (state_q == S_OOR) begin
        out_sym_q  <= SYM_ROUND_OPEN;
        out_oor_q  <= 1'b1;
        out_last_q <= 1'b1;
      end else begin
        out_sym_q  <= dec_sym;
        out_oor_q  <= 1'b0;
        out_last_q <= (rest == '0);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = out_sym_q;
  assign out_of_range_o = out_oor_q;
  assign last_o         = out_last_q;

endmodule
